// File: rtl/core/iirst_pkg.sv
// Shared types, register codes and constants of the sparse-tap IIR filter.
package iirst_pkg;

   // Coefficients carry 14 fraction bits (Q2.14 at the default width).
   localparam int FRAC_BITS = 14;

   // Number of weighted taps: three feed-forward, five feedback.
   localparam int NUM_TAPS = 8;

   // History depths of the input and output delay lines.
   localparam int IN_DEPTH  = 9;
   localparam int OUT_DEPTH = 10;

   // Register index port width; codes past the last register are ignored.
   localparam int CSR_INDEX_W = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_COEF_B5  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_B7  = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_B9  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_A2  = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_A4  = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_A6  = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_A8  = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_A10 = 4'd7;

   // Status that travels with a finished sum from the arithmetic unit.
   typedef struct packed {
      logic valid;
      logic clipped;
   } iirst_status_type;

   // Reset value of each coefficient register, as a 32-bit signed constant.
   function automatic logic signed [31:0] coef_reset(input logic [CSR_INDEX_W-1:0] idx);
      logic signed [31:0] value;
      begin
         case (idx)
            REG_COEF_B5:  value = 32'sd16384;
            REG_COEF_B7:  value = -32'sd9994;
            REG_COEF_B9:  value = 32'sd1475;
            REG_COEF_A2:  value = 32'sd7373;
            REG_COEF_A4:  value = 32'sd4157;
            REG_COEF_A6:  value = -32'sd5014;
            REG_COEF_A8:  value = -32'sd4206;
            REG_COEF_A10: value = -32'sd336;
            default:      value = 32'sd0;
         endcase
         return value;
      end
   endfunction

endpackage

// File: rtl/core/iirst_cell.sv
// One delay-line cell: holds a sample and passes it to its neighbor on a shift.
module iirst_cell #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           shift_en,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
   output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

   logic signed [SAMPLE_WIDTH-1:0] sample_ff;
   logic signed [SAMPLE_WIDTH-1:0] sample_in_d;

   // Take the neighbor's sample on a shift, otherwise hold.
   assign sample_in_d = shift_en ? sample_in : sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in_d;
      end
   end

   assign sample_out = sample_ff;

endmodule

// File: rtl/core/iirst_mac.sv
// Tap multipliers, product registers, and the round/shift/saturate stage.
module iirst_mac #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic signed [SAMPLE_WIDTH-1:0]      tap_sample [iirst_pkg::NUM_TAPS],
   input  logic signed [COEF_WIDTH-1:0]        tap_coef   [iirst_pkg::NUM_TAPS],
   output logic signed [SAMPLE_WIDTH-1:0]      y_sample,
   output iirst_pkg::iirst_status_type         status
);

   import iirst_pkg::*;

   localparam int PROD_W  = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int SUM_W   = PROD_W + $clog2(NUM_TAPS) + 1;
   localparam int SHIFT_W = SUM_W - FRAC_BITS;

   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   logic signed [PROD_W-1:0]  product_ff [NUM_TAPS];
   logic signed [PROD_W-1:0]  product_in [NUM_TAPS];
   logic                      valid_ff;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SHIFT_W-1:0] shifted;
   logic [SHIFT_W-SAMPLE_WIDTH:0] upper;
   logic                      in_range;

   // Stage one: one multiplier per tap, products registered.
   always_comb begin
      for (int i = 0; i < NUM_TAPS; i++) begin
         product_in[i] = PROD_W'(tap_sample[i]) * PROD_W'(tap_coef[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= load;
      end
   end

   // Stage two: exact sum with the rounding half added, then floor shift.
   always_comb begin
      sum = ROUND_HALF;
      for (int i = 0; i < NUM_TAPS; i++) begin
         sum = sum + SUM_W'(product_ff[i]);
      end
   end

   assign shifted = SHIFT_W'(sum >>> FRAC_BITS);

   // The value fits when every bit above the sample's sign bit matches it.
   assign upper    = shifted[SHIFT_W-1:SAMPLE_WIDTH-1];
   assign in_range = (&upper) | ~(|upper);

   always_comb begin
      if (in_range) begin
         y_sample = shifted[SAMPLE_WIDTH-1:0];
      end else if (shifted[SHIFT_W-1]) begin
         y_sample = SAMPLE_MIN;
      end else begin
         y_sample = SAMPLE_MAX;
      end
   end

   assign status.valid   = valid_ff;
   assign status.clipped = ~in_range;

endmodule

// File: rtl/core/iir_sparse_tap_filter.sv
// Top level of the sparse-tap direct-form-1 IIR filter.
//
//  Channel  Direction  Handshake            Payload
//  req      in         req_valid/req_ready  req_x_sample
//  rsp      out        rsp_valid/rsp_ready  rsp_y_sample, rsp_clipped
//  csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One sample is accepted per cycle while req_ready is high; its result
// goes from the product registers into the queue. The rate is set by the y[n-2]
// feedback loop, which runs through the product registers and the sum stage.
// Reset clears both delay lines, reloads the coefficient defaults and empties
// the result queue. A four-entry result queue absorbs output stalls; req_ready
// drops only when the queue and the transaction in flight would fill it.
module iir_sparse_tap_filter #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_x_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_y_sample,
   output logic                                   rsp_clipped,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [iirst_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [COEF_WIDTH-1:0]                  csr_wdata
);

   import iirst_pkg::*;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   logic signed [COEF_WIDTH-1:0]   coef_ff [NUM_TAPS];
   logic signed [SAMPLE_WIDTH-1:0] in_chain  [IN_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] out_chain [OUT_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] tap_sample [NUM_TAPS];
   logic signed [SAMPLE_WIDTH-1:0] mac_y;
   iirst_status_type               mac_status;
   logic                           req_accept;
   logic                           rsp_accept;

   logic signed [SAMPLE_WIDTH-1:0] y_mem_ff    [FIFO_DEPTH];
   logic                           clip_mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]               wr_ptr_ff;
   logic [PTR_W-1:0]               rd_ptr_ff;
   logic [CNT_W-1:0]               count_ff;
   logic [CNT_W-1:0]               count_in;
   logic [CNT_W:0]                 occupancy;

   assign req_accept = req_valid & req_ready;
   assign rsp_accept = rsp_valid & rsp_ready;

   // Coefficient registers; writes to unknown indexes fall through.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TAPS; i++) begin
            coef_ff[i] <= COEF_WIDTH'(coef_reset(CSR_INDEX_W'(i)));
         end
      end else if (csr_valid && csr_ready) begin
         for (int i = 0; i < NUM_TAPS; i++) begin
            if (csr_index == CSR_INDEX_W'(i)) begin
               coef_ff[i] <= csr_wdata;
            end
         end
      end
   end

   // Input delay line: shifts once per accepted transaction.
   for (genvar g = 0; g < IN_DEPTH; g++) begin : g_in_cell
      iirst_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (req_accept),
         .sample_in  ((g == 0) ? req_x_sample : in_chain[(g == 0) ? 0 : g - 1]),
         .sample_out (in_chain[g])
      );
   end

   // Output delay line: shifts once per finished result.
   for (genvar g = 0; g < OUT_DEPTH; g++) begin : g_out_cell
      iirst_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (mac_status.valid),
         .sample_in  ((g == 0) ? mac_y : out_chain[(g == 0) ? 0 : g - 1]),
         .sample_out (out_chain[g])
      );
   end

   // Tap selection. While the previous transaction is still in the sum stage,
   // its output has not entered the line yet, so every feedback tap sits one
   // cell closer to the head.
   always_comb begin
      tap_sample[0] = in_chain[4];
      tap_sample[1] = in_chain[6];
      tap_sample[2] = in_chain[8];
      for (int k = 0; k < 5; k++) begin
         tap_sample[3 + k] = mac_status.valid ? out_chain[2 * k] : out_chain[2 * k + 1];
      end
   end

   iirst_mac #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .tap_sample (tap_sample),
      .tap_coef   (coef_ff),
      .y_sample   (mac_y),
      .status     (mac_status)
   );

   // Result queue. Accept a new sample only if it is sure to find a slot.
   assign occupancy = (CNT_W + 1)'(count_ff) + (CNT_W + 1)'(mac_status.valid);
   assign req_ready = occupancy < (CNT_W + 1)'(FIFO_DEPTH);

   always_ff @(posedge clock) begin
      if (mac_status.valid) begin
         y_mem_ff[wr_ptr_ff]    <= mac_y;
         clip_mem_ff[wr_ptr_ff] <= mac_status.clipped;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (mac_status.valid && !rsp_accept) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!mac_status.valid && rsp_accept) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (mac_status.valid) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (rsp_accept) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   assign rsp_valid    = count_ff != '0;
   assign rsp_y_sample = y_mem_ff[rd_ptr_ff];
   assign rsp_clipped  = clip_mem_ff[rd_ptr_ff];

endmodule

// File: rtl/core/iirst_checker.sv
// Port-level checks of the sparse-tap IIR filter, bound to its top level.
module iirst_checker #(
   parameter int SAMPLE_WIDTH = 16
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_y_sample,
   input logic                           rsp_clipped,
   input logic                           csr_ready
);

   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   // The result queue is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Every accepted transaction shows a result after the product registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> ##1 rsp_valid)
      else $error("no result two cycles after an accepted sample");

   // A saturated result is at one end of the sample range.
   a_clip_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |-> (rsp_y_sample == SAMPLE_MAX || rsp_y_sample == SAMPLE_MIN))
      else $error("clipped result is not a range limit");

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_y_sample) && $stable(rsp_clipped)))
      else $error("stalled result changed");

   // Coefficient writes are never back-pressured outside reset.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("configuration port not ready");

endmodule

bind iir_sparse_tap_filter iirst_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_iirst_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_y_sample (rsp_y_sample),
   .rsp_clipped  (rsp_clipped),
   .csr_ready    (csr_ready)
);

// File: bench/iirst_tb_pkg.sv
// Scoreboard of the sparse-tap IIR filter testbench, with its own filter predictor.
`timescale 1ns / 1ps
package iirst_tb_pkg;
   import iirst_pkg::*;

   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 16;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef logic signed [COEF_W-1:0] coef_set_type [NUM_TAPS];

   // Coefficients after reset, in register order (Q2.14).
   localparam coef_set_type COEF_DEFAULTS = '{
      16'sd16384, -16'sd9994, 16'sd1475, 16'sd7373,
      16'sd4157, -16'sd5014, -16'sd4206, -16'sd336
   };

   // One filtered sample as it should leave the block.
   typedef struct {
      logic signed [SAMPLE_W-1:0] y_sample;
      logic                       clipped;
   } filter_out_type;

   class iirst_scoreboard;
      logic signed [COEF_W-1:0]   coef [NUM_TAPS];
      // Entry k of a history holds the sample k+1 steps back.
      logic signed [SAMPLE_W-1:0] x_hist [IN_DEPTH];
      logic signed [SAMPLE_W-1:0] y_hist [OUT_DEPTH];
      filter_out_type             y_expected_q [$];
      int                         errors;

      function new();
         foreach (coef[i]) coef[i] = COEF_DEFAULTS[i];
         foreach (x_hist[i]) x_hist[i] = '0;
         foreach (y_hist[i]) y_hist[i] = '0;
         errors = 0;
      endfunction

      // A register write takes effect only for a known index.
      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [COEF_W-1:0] data);
         if (idx <= REG_COEF_A10) begin
            coef[idx] = data;
         end
      endfunction

      // Filter one accepted sample and queue the output it must produce.
      function void note_sample(logic signed [SAMPLE_W-1:0] x);
         longint         acc;
         longint         scaled;
         filter_out_type res;
         // Exact sum of the eight products plus half an LSB for rounding.
         acc = longint'(1) <<< (FRAC_BITS - 1);
         acc += longint'(coef[REG_COEF_B5])  * longint'(x_hist[4]);
         acc += longint'(coef[REG_COEF_B7])  * longint'(x_hist[6]);
         acc += longint'(coef[REG_COEF_B9])  * longint'(x_hist[8]);
         acc += longint'(coef[REG_COEF_A2])  * longint'(y_hist[1]);
         acc += longint'(coef[REG_COEF_A4])  * longint'(y_hist[3]);
         acc += longint'(coef[REG_COEF_A6])  * longint'(y_hist[5]);
         acc += longint'(coef[REG_COEF_A8])  * longint'(y_hist[7]);
         acc += longint'(coef[REG_COEF_A10]) * longint'(y_hist[9]);
         scaled = acc >>> FRAC_BITS;

         // Saturate to the sample range and flag it.
         res.clipped = 1'b1;
         if (scaled > longint'(SAMPLE_MAX)) begin
            res.y_sample = SAMPLE_MAX;
         end else if (scaled < longint'(SAMPLE_MIN)) begin
            res.y_sample = SAMPLE_MIN;
         end else begin
            res.y_sample = scaled[SAMPLE_W-1:0];
            res.clipped  = 1'b0;
         end

         // The new sample and the saturated output enter the delay lines.
         for (int i = IN_DEPTH - 1; i > 0; i--) x_hist[i] = x_hist[i-1];
         x_hist[0] = x;
         for (int i = OUT_DEPTH - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
         y_hist[0] = res.y_sample;
         y_expected_q.push_back(res);
      endfunction

      // Compare one accepted result with the oldest expected output.
      function void check_result(logic signed [SAMPLE_W-1:0] y, logic clipped);
         filter_out_type exp_res;
         if (y_expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got y_sample %0d clipped %0b",
                     $time, y, clipped);
         end else begin
            exp_res = y_expected_q.pop_front();
            if (y !== exp_res.y_sample) begin
               errors++;
               $display("%0t: y_sample mismatch, expected %0d, got %0d",
                        $time, exp_res.y_sample, y);
            end
            if (clipped !== exp_res.clipped) begin
               errors++;
               $display("%0t: clipped mismatch, expected %0b, got %0b",
                        $time, exp_res.clipped, clipped);
            end
         end
      endfunction

      function int pending();
         return y_expected_q.size();
      endfunction
   endclass

endpackage

// File: bench/iir_sparse_tap_filter_tb.sv
// Testbench top of the sparse-tap IIR filter: clock, reset, stimulus and result checks.
`timescale 1ns / 1ps
module iir_sparse_tap_filter_tb;
   import iirst_pkg::*;
   import iirst_tb_pkg::*;

   localparam int RANDOM_PHASES    = 12;
   localparam int ITEMS_PER_PHASE  = 96;
   localparam int PRESSURE_PHASE   = 1;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int SETTLE_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT   = 3000;

   localparam logic signed [COEF_W-1:0] COEF_HALF = 16'sd8192;
   localparam logic signed [COEF_W-1:0] COEF_MIN  = 16'sh8000;
   localparam logic signed [COEF_W-1:0] COEF_MAX  = 16'sh7fff;

   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_FIRST = REG_COEF_A10 + 1'b1;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_LAST  = {CSR_INDEX_W{1'b1}};

   // How a random phase chooses its coefficients.
   typedef enum int {
      COEFS_DEFAULT,
      COEFS_STABLE,
      COEFS_RANDOM,
      COEFS_EXTREME
   } coef_style_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_W-1:0]    req_x_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0]    rsp_y_sample;
   logic                          rsp_clipped;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_W-1:0]        csr_index = '0;
   logic [COEF_W-1:0]             csr_wdata = '0;

   bit                            hold_request = 1'b0;
   bit                            tail_quiet = 1'b0;
   int                            idle_cycles = 0;
   iirst_scoreboard               filter_check;

   iir_sparse_tap_filter #(
      .SAMPLE_WIDTH (SAMPLE_W),
      .COEF_WIDTH   (COEF_W)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_x_sample (req_x_sample),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_y_sample (rsp_y_sample),
      .rsp_clipped  (rsp_clipped),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Every transaction on the three channels goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            filter_check.write_reg(csr_index, csr_wdata);
         end
         if (req_valid && req_ready) begin
            filter_check.note_sample(req_x_sample);
         end
         if (rsp_valid && rsp_ready) begin
            filter_check.check_result(rsp_y_sample, rsp_clipped);
         end
      end
   end

   // Watchdog: too long without any transaction ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Result side: random stall bursts, one long hold-off on request, none at the tail.
   initial begin : result_sink
      @(negedge reset);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (tail_quiet || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   // Offer one sample, sometimes after an idle burst, and hold it until accepted.
   // Valid stays high afterwards so the next sample can follow back to back.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input bit may_pause);
      if (may_pause && !tail_quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_x_sample <= x;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering samples and let every outstanding output come back.
   // A clock edge passes first so the scoreboard sees the last accepted sample.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (filter_check.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all coefficient registers, then one random index past the last register.
   task automatic load_coefs(input coef_set_type values);
      logic [CSR_INDEX_W-1:0] idx;
      idx = REG_COEF_B5;
      repeat (NUM_TAPS) begin
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= values[idx];
         do @(posedge clock); while (!csr_ready);
         idx++;
      end
      // A write to an unknown index must leave every coefficient alone.
      csr_index <= CSR_INDEX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST));
      csr_wdata <= COEF_W'($urandom);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         3, 4:    return SAMPLE_W'($signed($urandom_range(0, 200)) - 100);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [COEF_W-1:0] pick_coef(coef_style_type style, int tap);
      case (style)
         COEFS_DEFAULT: return COEF_DEFAULTS[tap];
         // Small feedback weights keep the loop stable; feed-forward weights are random.
         COEFS_STABLE: begin
            if (tap >= REG_COEF_A2) begin
               return COEF_W'($signed($urandom_range(0, 4000)) - 2000);
            end else begin
               return COEF_W'($urandom);
            end
         end
         COEFS_EXTREME: return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
         default:       return COEF_W'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      coef_set_type   coefs;
      coef_style_type style;

      filter_check = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default coefficients: full-scale samples followed by silence, so the
      // response is seen only from five samples on and then rings through feedback.
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(SAMPLE_MIN, 1'b1);
      repeat (8) send_sample('0, 1'b1);

      // Only b5 at one half: odd inputs land exactly on rounding ties, which
      // must round upward for both signs.
      wait_drained();
      foreach (coefs[i]) coefs[i] = '0;
      coefs[REG_COEF_B5] = COEF_HALF;
      load_coefs(coefs);
      send_sample(16'sd1, 1'b1);
      send_sample(-16'sd1, 1'b1);
      send_sample(16'sd3, 1'b1);
      send_sample(-16'sd3, 1'b1);
      repeat (5) send_sample('0, 1'b1);

      // Extreme coefficients drive the sum far past both ends of the range.
      wait_drained();
      foreach (coefs[i]) coefs[i] = (i >= REG_COEF_A2) ? COEF_MAX : COEF_MIN;
      load_coefs(coefs);
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(SAMPLE_MIN, 1'b1);
      repeat (5) send_sample('0, 1'b1);

      // Random phases, each loading a set in the next coefficient style. One phase runs
      // against a long output hold-off; the last one runs without idling.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         style = coef_style_type'(phase % 4);
         foreach (coefs[i]) coefs[i] = pick_coef(style, i);
         load_coefs(coefs);
         tail_quiet   = (phase == RANDOM_PHASES - 1);
         hold_request = (phase == PRESSURE_PHASE);
         repeat (ITEMS_PER_PHASE) send_sample(pick_sample(), phase != PRESSURE_PHASE);
      end
      wait_drained();

      if (filter_check.errors == 0 && filter_check.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
